// File: src/ltlf_pkg.sv
// Package for the length table log framer.
// Header codes, descriptor length and the structs passed between modules.
// Depends on nothing.
`default_nettype none

package ltlf_pkg;

   localparam int DESCRIPTOR_LENGTH = 89;
   localparam logic [7:0] DESC_TOTAL = 8'(DESCRIPTOR_LENGTH % 256);

   localparam logic [7:0] HDR_FIRST  = 8'hA3;
   localparam logic [7:0] HDR_SECOND = 8'h95;
   localparam logic [7:0] DESC_TYPE  = 8'h80;

   localparam logic [7:0] POS_HDR_FIRST  = 8'd0;
   localparam logic [7:0] POS_HDR_SECOND = 8'd1;
   localparam logic [7:0] POS_TYPE       = 8'd2;
   localparam logic [7:0] POS_BODY_FIRST = 8'd3;
   localparam logic [7:0] MIN_TOTAL      = 8'd4;

   typedef struct packed {
      logic       rd_en;
      logic [7:0] rd_addr;
      logic       wr_en;
      logic [7:0] wr_addr;
      logic [7:0] wr_data;
   } table_req_type;

   typedef struct packed {
      logic       valid;
      logic [7:0] out_byte;
      logic [7:0] msg_type;
      logic [7:0] byte_index;
      logic       last_of_packet;
   } result_type;

endpackage

`default_nettype wire

// File: src/ltlf_len_table.sv
// Length table: 256 x 8 synchronous memory with registered read.
// Per-entry valid bits cleared at reset; an unwritten entry reads as zero.
// Depends on ltlf_pkg.
`default_nettype none

module ltlf_len_table
   import ltlf_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire table_req_type tbl_req,
   output logic [7:0]         rd_data
);

   logic [7:0]   mem [256];
   logic [255:0] valid_ff;
   logic [255:0] valid_in;
   logic [7:0]   rd_data_ff;
   logic         rd_vld_ff;

   always_comb begin
      valid_in = valid_ff;
      if (tbl_req.wr_en) begin
         valid_in[tbl_req.wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         if (tbl_req.rd_en) begin
            rd_vld_ff <= valid_ff[tbl_req.rd_addr];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (tbl_req.wr_en) begin
         mem[tbl_req.wr_addr] <= tbl_req.wr_data;
      end
      if (tbl_req.rd_en) begin
         rd_data_ff <= mem[tbl_req.rd_addr];
      end
   end

   assign rd_data = rd_vld_ff ? rd_data_ff : 8'd0;

endmodule

`default_nettype wire

// File: src/ltlf_framer_ctrl.sv
// Framing control: header hunt, position count, descriptor capture.
// Issues length table reads and writes and forms one result per data packet body byte.
// Depends on ltlf_pkg.
`default_nettype none

module ltlf_framer_ctrl
   import ltlf_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          accept,
   input  wire logic [7:0]    in_byte,
   input  wire logic [7:0]    rd_data,
   output table_req_type      tbl_req,
   output result_type         result
);

   logic [7:0] pos_ff,   pos_in;
   logic [7:0] total_ff, total_in;
   logic       desc_ff,  desc_in;
   logic [7:0] type_ff,  type_in;
   logic [7:0] dtype_ff, dtype_in;
   logic [7:0] dlen_ff,  dlen_in;

   logic [7:0] total;
   logic [7:0] idx;
   logic       last;

   always_comb begin
      total = (pos_ff == POS_BODY_FIRST) ? (desc_ff ? DESC_TOTAL : rd_data) : total_ff;
      idx   = pos_ff - POS_BODY_FIRST;
      last  = (pos_ff == total - 8'd1);
   end

   always_comb begin
      pos_in   = pos_ff;
      total_in = total_ff;
      desc_in  = desc_ff;
      type_in  = type_ff;
      dtype_in = dtype_ff;
      dlen_in  = dlen_ff;
      tbl_req  = '0;
      result   = '0;
      result.out_byte       = in_byte;
      result.msg_type       = type_ff;
      result.byte_index     = idx;
      result.last_of_packet = last;
      if (accept) begin
         priority if (pos_ff == POS_HDR_FIRST) begin
            if (in_byte == HDR_FIRST) begin
               pos_in = POS_HDR_SECOND;
            end
         end else if (pos_ff == POS_HDR_SECOND) begin
            if (in_byte == HDR_SECOND) begin
               pos_in = POS_TYPE;
            end else begin
               pos_in   = POS_HDR_FIRST;
               total_in = 8'd0;
               desc_in  = 1'b0;
            end
         end else if (pos_ff == POS_TYPE) begin
            type_in         = in_byte;
            desc_in         = (in_byte == DESC_TYPE);
            tbl_req.rd_en   = 1'b1;
            tbl_req.rd_addr = in_byte;
            pos_in          = POS_BODY_FIRST;
         end else begin
            total_in = total;
            if (total < MIN_TOTAL || pos_ff > total - 8'd1) begin
               pos_in   = POS_HDR_FIRST;
               total_in = 8'd0;
               desc_in  = 1'b0;
            end else begin
               if (desc_ff) begin
                  if (idx == 8'd0) begin
                     dtype_in = in_byte;
                  end else if (idx == 8'd1) begin
                     dlen_in = in_byte;
                  end
                  tbl_req.wr_en   = last;
                  tbl_req.wr_addr = dtype_in;
                  tbl_req.wr_data = dlen_in;
               end else begin
                  result.valid = 1'b1;
               end
               if (last) begin
                  pos_in   = POS_HDR_FIRST;
                  total_in = 8'd0;
                  desc_in  = 1'b0;
               end else begin
                  pos_in = pos_ff + 8'd1;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= POS_HDR_FIRST;
         total_ff <= 8'd0;
         desc_ff  <= 1'b0;
         type_ff  <= 8'd0;
         dtype_ff <= 8'd0;
         dlen_ff  <= 8'd0;
      end else begin
         pos_ff   <= pos_in;
         total_ff <= total_in;
         desc_ff  <= desc_in;
         type_ff  <= type_in;
         dtype_ff <= dtype_in;
         dlen_ff  <= dlen_in;
      end
   end

endmodule

`default_nettype wire

// File: src/ltlf_out_reg.sv
// Result output register with valid/stall handshake.
// Refills in the cycle its transaction is taken; stalls the input when held.
// Depends on ltlf_pkg.
`default_nettype none

module ltlf_out_reg
   import ltlf_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire result_type result,
   input  wire logic       rsp_stall,
   output logic            busy,
   output logic            rsp_valid,
   output logic [7:0]      rsp_out_byte,
   output logic [7:0]      rsp_msg_type,
   output logic [7:0]      rsp_byte_index,
   output logic            rsp_last_of_packet
);

   result_type res_ff;
   logic       vld_ff, vld_in;

   assign busy   = vld_ff && rsp_stall;
   assign vld_in = busy ? 1'b1 : result.valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (!busy) begin
         res_ff <= result;
      end
   end

   assign rsp_valid          = vld_ff;
   assign rsp_out_byte       = res_ff.out_byte;
   assign rsp_msg_type       = res_ff.msg_type;
   assign rsp_byte_index     = res_ff.byte_index;
   assign rsp_last_of_packet = res_ff.last_of_packet;

endmodule

`default_nettype wire

// File: src/length_table_log_framer.sv
// Length table log framer, top level.
// Frames a self-describing binary log stream one byte per transaction.
// Request channel: req_valid/req_stall carry one raw byte, req_in_byte.
// Header A3 95 and a type byte open a packet; type 80 is a format
// descriptor whose body sets a type's total length in a 256-entry table.
// Descriptors are consumed silently. Data packet body bytes come out on
// the response channel (rsp_valid/rsp_stall) with the type, body index
// and a last flag; header and type bytes give no response.
// Throughput: one byte per cycle while no response is held by rsp_stall, set by
// the single table read issued at the type byte and consumed at the first body byte.
// A body byte appears on rsp_ in the cycle after its acceptance, from the response register.
// Reset (synchronous, active high) restarts the hunt and clears all
// table entries at once through per-entry valid bits; no clearing pass.
// While rsp_stall holds a pending response, req_stall is raised and no
// further byte is taken; the response register refills as it drains.
// Depends on ltlf_pkg, ltlf_len_table, ltlf_framer_ctrl, ltlf_out_reg.
`default_nettype none

module length_table_log_framer
   import ltlf_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [7:0] req_in_byte,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [7:0]      rsp_out_byte,
   output logic [7:0]      rsp_msg_type,
   output logic [7:0]      rsp_byte_index,
   output logic            rsp_last_of_packet
);

   table_req_type tbl_req;
   result_type    result;
   logic [7:0]    rd_data;
   logic          busy;
   logic          accept;

   assign req_stall = busy;
   assign accept    = req_valid && !busy;

   ltlf_len_table u_table (
      .clock   (clock),
      .reset   (reset),
      .tbl_req (tbl_req),
      .rd_data (rd_data)
   );

   ltlf_framer_ctrl u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .in_byte (req_in_byte),
      .rd_data (rd_data),
      .tbl_req (tbl_req),
      .result  (result)
   );

   ltlf_out_reg u_out (
      .clock              (clock),
      .reset              (reset),
      .result             (result),
      .rsp_stall          (rsp_stall),
      .busy               (busy),
      .rsp_valid          (rsp_valid),
      .rsp_out_byte       (rsp_out_byte),
      .rsp_msg_type       (rsp_msg_type),
      .rsp_byte_index     (rsp_byte_index),
      .rsp_last_of_packet (rsp_last_of_packet)
   );

endmodule

`default_nettype wire

// File: dv/framer_scoreboard_pkg.sv
// Scoreboard for the length table log framer testbench: predicts framed body bytes
// from the accepted input bytes and checks each response against the oldest prediction.
// Depends on ltlf_pkg for header codes and the descriptor length.
`timescale 1ns / 100ps

package framer_scoreboard_pkg;
   import ltlf_pkg::*;

   typedef struct packed {
      logic [7:0] data;
      logic [7:0] ptype;
      logic [7:0] index;
      logic       last;
   } body_byte_type;

   class framer_scoreboard;
      logic [7:0]    position;
      logic [7:0]    total;
      logic          in_descriptor;
      logic [7:0]    msg_type;
      logic [7:0]    type_length [256];
      logic [7:0]    described_type;
      logic [7:0]    described_length;
      body_byte_type expected_bytes [$];
      int            errors;

      function new();
         position = POS_HDR_FIRST;
         total = '0;
         in_descriptor = 1'b0;
         msg_type = '0;
         foreach (type_length[i])
            type_length[i] = '0;
         described_type = '0;
         described_length = '0;
         errors = 0;
      endfunction

      function logic [7:0] length_of(logic [7:0] t);
         return type_length[t];
      endfunction

      function int pending();
         return expected_bytes.size();
      endfunction

      function void restart();
         position = POS_HDR_FIRST;
         total = '0;
         in_descriptor = 1'b0;
      endfunction

      function void note_byte(logic [7:0] b);
         logic [7:0]    idx;
         logic          last;
         body_byte_type item;
         if (position == POS_HDR_FIRST) begin
            if (b == HDR_FIRST)
               position = POS_HDR_SECOND;
         end else if (position == POS_HDR_SECOND) begin
            if (b == HDR_SECOND)
               position = POS_TYPE;
            else
               restart();
         end else if (position == POS_TYPE) begin
            msg_type = b;
            in_descriptor = (b == DESC_TYPE);
            total = in_descriptor ? DESC_TOTAL : type_length[b];
            position = POS_BODY_FIRST;
         end else if (total < MIN_TOTAL || position > total - 8'd1) begin
            restart();
         end else begin
            idx = position - POS_BODY_FIRST;
            last = (position == total - 8'd1);
            if (in_descriptor) begin
               if (idx == 8'd0)
                  described_type = b;
               else if (idx == 8'd1)
                  described_length = b;
               if (last)
                  type_length[described_type] = described_length;
            end else begin
               item = '{data: b, ptype: msg_type, index: idx, last: last};
               expected_bytes.push_back(item);
            end
            if (last)
               restart();
            else
               position = position + 8'd1;
         end
      endfunction

      function void check_result(body_byte_type got);
         body_byte_type want;
         if (expected_bytes.size() == 0) begin
            errors++;
            $display("%0t: unexpected transaction byte %02h type %02h index %0d last %0b",
                     $time, got.data, got.ptype, got.index, got.last);
            return;
         end
         want = expected_bytes.pop_front();
         if (got !== want) begin
            errors++;
            $display("%0t: expected %02h/%02h/%0d/%0b actual %02h/%02h/%0d/%0b",
                     $time, want.data, want.ptype, want.index, want.last,
                     got.data, got.ptype, got.index, got.last);
         end
      endfunction
   endclass

endpackage

// File: dv/testbench.sv
// Top-level testbench for length_table_log_framer: directed and random log streams
// with random idling on both channels, checked by framer_scoreboard.
// Depends on ltlf_pkg, framer_scoreboard_pkg and the framer RTL.
`timescale 1ns / 100ps

module testbench;
   import ltlf_pkg::*;
   import framer_scoreboard_pkg::*;

   localparam int ITEMS          = 1950;
   localparam int HOLD_CYCLES    = 80;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = 8;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_in_byte = 8'h00;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [7:0] rsp_out_byte;
   logic [7:0] rsp_msg_type;
   logic [7:0] rsp_byte_index;
   logic       rsp_last_of_packet;

   int         send_idle_pct = 28;
   int         recv_idle_pct = 65;
   int         bytes_sent = 0;
   logic       hold_armed = 1'b0;
   logic       hold_taken = 1'b0;
   int         hold_left = 0;
   int         quiet_cycles = 0;
   logic [7:0] type_pool [8];
   framer_scoreboard sb;

   length_table_log_framer DUT (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_in_byte        (req_in_byte),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_out_byte       (rsp_out_byte),
      .rsp_msg_type       (rsp_msg_type),
      .rsp_byte_index     (rsp_byte_index),
      .rsp_last_of_packet (rsp_last_of_packet)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall)
            sb.check_result(body_byte_type'{rsp_out_byte, rsp_msg_type, rsp_byte_index,
                                            rsp_last_of_packet});
         if (hold_armed && !hold_taken) begin
            hold_taken <= 1'b1;
            hold_left <= HOLD_CYCLES;
            rsp_stall <= 1'b1;
         end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < recv_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   task automatic send_byte(input logic [7:0] b);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_in_byte <= b;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      sb.note_byte(b);
      bytes_sent++;
   endtask

   task automatic send_header(input logic [7:0] t);
      send_byte(HDR_FIRST);
      send_byte(HDR_SECOND);
      send_byte(t);
   endtask

   task automatic send_descriptor(input logic [7:0] dtype, input logic [7:0] dlen);
      send_header(DESC_TYPE);
      send_byte(dtype);
      send_byte(dlen);
      for (int i = 5; i < int'(DESC_TOTAL); i++)
         send_byte(8'($urandom));
   endtask

   // cut > 0 and below the body length truncates the body, leaving the framer mid-packet
   task automatic send_packet(input logic [7:0] t, input int cut);
      int body;
      body = (sb.length_of(t) < MIN_TOTAL) ? 1 : int'(sb.length_of(t)) - 3;
      if (cut > 0 && cut < body)
         body = cut;
      send_header(t);
      for (int i = 0; i < body; i++)
         send_byte(8'($urandom));
   endtask

   initial begin
      int         choice;
      int         phase;
      int         next_phase;
      logic [7:0] t;
      sb = new();
      type_pool = '{8'h00, 8'hFF, 8'h01, 8'h7F, DESC_TYPE, 8'h55, 8'hAA, 8'h00};
      type_pool[7] = 8'($urandom);
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(HDR_SECOND);
      send_byte(HDR_FIRST);
      send_byte(HDR_FIRST);
      send_byte(HDR_SECOND);
      send_header(8'h00);
      send_byte(8'h42);
      send_descriptor(8'h01, MIN_TOTAL);
      send_packet(8'h01, 0);
      send_descriptor(8'h02, 8'h03);
      send_packet(8'h02, 0);
      send_descriptor(8'hFF, 8'h06);
      send_header(8'hFF);
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(HDR_FIRST);
      send_descriptor(DESC_TYPE, 8'h0A);
      send_packet(8'hFF, 0);

      phase = 0;
      while (bytes_sent < ITEMS) begin
         next_phase = bytes_sent * 3 / ITEMS;
         if (next_phase != phase) begin
            phase = next_phase;
            req_valid <= 1'b0;
            @(posedge clock);
            while (sb.pending() != 0)
               @(posedge clock);
            if (phase == 1) begin
               send_idle_pct = 65;
               recv_idle_pct = 28;
            end else begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
               send_descriptor(8'hFF, 8'hFF);
               hold_armed <= 1'b1;
               send_packet(8'hFF, 0);
            end
         end
         choice = $urandom_range(99);
         if (choice < 7) begin
            t = type_pool[$urandom_range(7)];
            choice = $urandom_range(99);
            if (choice < 72)
               send_descriptor(t, 8'($urandom_range(24, 4)));
            else if (choice < 88)
               send_descriptor(t, 8'($urandom_range(3, 0)));
            else
               send_descriptor(t, 8'($urandom_range(255, 25)));
         end else if (choice < 85) begin
            t = type_pool[$urandom_range(7)];
            if (t != DESC_TYPE)
               send_packet(t, ($urandom_range(11) == 0) ? int'($urandom_range(12, 1)) : 0);
         end else if (choice < 93) begin
            repeat ($urandom_range(4, 1))
               send_byte(8'($urandom));
         end else begin
            send_byte(HDR_FIRST);
            if ($urandom_range(1) == 0) begin
               send_byte(8'($urandom));
            end else begin
               send_byte(HDR_SECOND);
               send_byte(8'($urandom));
               send_byte(8'($urandom));
            end
         end
      end

      req_valid <= 1'b0;
      while (sb.pending() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
